// ===== rtl/console_line_editor_defines.svh =====
// Assertion macros for the console line editor checker.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CLE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CLE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// Shared constants, codes and types of the console line editor.
// No dependencies; imported by the front end, queue, back end and top level.
`timescale 1ns / 1ps
package cle_pkg;

   // Line capacity and derived widths.
   localparam int LINE_CAP = 63;
   localparam int CNT_W = 6;
   localparam int ADDR_W = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
   localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(LINE_CAP);
   localparam logic [CNT_W-1:0] MAX_CHARS_RESET = 6'd63;

   // Command queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Character codes.
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_KILL = 8'h15;
   localparam logic [7:0] CH_RETYPE = 8'h12;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LOW = 8'h20;
   localparam logic [7:0] CH_HIGH = 8'h7E;

   localparam logic OP_START = 1'b0;

   typedef enum logic [2:0] {
      CMD_START,
      CMD_NEWLINE,
      CMD_ERASE,
      CMD_KILL,
      CMD_RETYPE,
      CMD_PRINT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_KILL,
      BK_RT_READ,
      BK_RT_EMIT
   } back_state_type;

   typedef struct packed {
      logic [1:0]       echo_count;
      logic [7:0]       echo_a;
      logic [7:0]       echo_b;
      logic [7:0]       echo_c;
      logic             store_valid;
      logic [CNT_W-1:0] store_index;
      logic             line_done;
      logic [CNT_W-1:0] line_length;
      logic             last;
   } rsp_word_type;

endpackage

// ===== rtl/cle_req_if.sv =====
// Input channel of the console line editor: valid/ready plus one input word.
// Depends on nothing.
`timescale 1ns / 1ps
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] char_in;

   modport source (output valid, opcode, char_in, input ready);
   modport sink (input valid, opcode, char_in, output ready);
endinterface

// ===== rtl/cle_rsp_if.sv =====
// Result channel of the console line editor: valid/ready plus one result word.
// Depends on nothing.
`timescale 1ns / 1ps
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] echo_count;
   logic [7:0] echo_a;
   logic [7:0] echo_b;
   logic [7:0] echo_c;
   logic       store_valid;
   logic [5:0] store_index;
   logic       line_done;
   logic [5:0] line_length;
   logic       last;

   modport source (output valid, echo_count, echo_a, echo_b, echo_c, store_valid,
                   store_index, line_done, line_length, last, input ready);
   modport sink (input valid, echo_count, echo_a, echo_b, echo_c, store_valid,
                 store_index, line_done, line_length, last, output ready);
endinterface

// ===== rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/cle_front.sv =====
// Front end: accepts input words and sorts them into editor commands.
// Depends on cle_pkg and cle_req_if; feeds cle_queue.
`timescale 1ns / 1ps
module cle_front (
   cle_req_if.sink          req,
   output logic             push_valid,
   output cle_pkg::cmd_type push_cmd,
   input  logic             push_ready
);
   import cle_pkg::*;

   logic keep_c;

   // Codes with no effect are dropped here and never reach the queue.
   always_comb begin
      keep_c = 1'b1;
      push_cmd.ch = req.char_in;
      push_cmd.kind = CMD_PRINT;
      if (req.opcode == OP_START) begin
         push_cmd.kind = CMD_START;
      end else if (req.char_in == CH_CR || req.char_in == CH_LF) begin
         push_cmd.kind = CMD_NEWLINE;
      end else if (req.char_in == CH_BS || req.char_in == CH_DEL) begin
         push_cmd.kind = CMD_ERASE;
      end else if (req.char_in == CH_KILL) begin
         push_cmd.kind = CMD_KILL;
      end else if (req.char_in == CH_RETYPE) begin
         push_cmd.kind = CMD_RETYPE;
      end else if (req.char_in >= CH_LOW && req.char_in <= CH_HIGH) begin
         push_cmd.kind = CMD_PRINT;
      end else begin
         keep_c = 1'b0;
      end
   end

   assign req.ready = push_ready;
   assign push_valid = req.valid && keep_c;
endmodule

// ===== rtl/cle_queue.sv =====
// Short command FIFO between the front end and the back end.
// Depends on cle_pkg.
`timescale 1ns / 1ps
module cle_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  cle_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   output cle_pkg::cmd_type pop_cmd,
   input  logic             pop
);
   import cle_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd = entry_ff[head_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      head_in = do_pop ? head_ff + 1'b1 : head_ff;
      tail_in = do_push ? tail_ff + 1'b1 : tail_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end
endmodule

// ===== rtl/cle_back.sv =====
// Back end: holds the line state, runs the editor commands and drives results.
// Depends on cle_pkg, cle_rsp_if and cle_ram (line store).
`timescale 1ns / 1ps
module cle_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [cle_pkg::CNT_W-1:0] max_chars,
   input  logic                    pop_valid,
   input  cle_pkg::cmd_type        pop_cmd,
   output logic                    pop,
   cle_rsp_if.source               rsp
);
   import cle_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              open_ff, open_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   rsp_word_type      out_ff, out_in;
   rsp_word_type      res_c;
   logic              slot_free;
   logic [CNT_W-1:0]  limit_c;
   logic              wr_en;
   logic [7:0]        rd_data;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign limit_c = (max_chars > CAP_LIMIT) ? CAP_LIMIT : max_chars;

   cle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CAP)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (pop_cmd.ch),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      open_in = open_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in = out_ff;
      res_c = '0;
      pop = 1'b0;
      wr_en = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid && slot_free) begin
               pop = 1'b1;
               case (pop_cmd.kind)
                  CMD_START: begin
                     count_in = '0;
                     if (limit_c == '0) begin
                        open_in = 1'b0;
                        res_c.line_done = 1'b1;
                        res_c.last = 1'b1;
                        out_valid_in = 1'b1;
                        out_in = res_c;
                     end else begin
                        open_in = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     if (open_ff) begin
                        res_c.echo_count = 2'd2;
                        res_c.echo_a = CH_CR;
                        res_c.echo_b = CH_LF;
                        res_c.line_done = 1'b1;
                        res_c.line_length = count_ff;
                        res_c.last = 1'b1;
                        out_valid_in = 1'b1;
                        out_in = res_c;
                        open_in = 1'b0;
                     end
                  end
                  CMD_ERASE: begin
                     if (open_ff && count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                        res_c.echo_count = 2'd3;
                        res_c.echo_a = CH_BS;
                        res_c.echo_b = CH_SP;
                        res_c.echo_c = CH_BS;
                        res_c.line_length = count_ff - 1'b1;
                        res_c.last = 1'b1;
                        out_valid_in = 1'b1;
                        out_in = res_c;
                     end
                  end
                  CMD_KILL: begin
                     if (open_ff && count_ff != '0) begin
                        state_in = BK_KILL;
                     end
                  end
                  CMD_RETYPE: begin
                     if (open_ff) begin
                        res_c.echo_count = 2'd3;
                        res_c.echo_a = CH_HASH;
                        res_c.echo_b = CH_CR;
                        res_c.echo_c = CH_LF;
                        res_c.line_length = count_ff;
                        res_c.last = (count_ff == '0);
                        out_valid_in = 1'b1;
                        out_in = res_c;
                        idx_in = '0;
                        if (count_ff != '0) begin
                           state_in = BK_RT_READ;
                        end
                     end
                  end
                  CMD_PRINT: begin
                     if (open_ff && count_ff < limit_c) begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                        res_c.echo_count = 2'd1;
                        res_c.echo_a = pop_cmd.ch;
                        res_c.store_valid = 1'b1;
                        res_c.store_index = count_ff;
                        res_c.line_length = count_ff + 1'b1;
                        res_c.last = 1'b1;
                        out_valid_in = 1'b1;
                        out_in = res_c;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_KILL: begin
            // one erase word per stored character
            if (slot_free) begin
               count_in = count_ff - 1'b1;
               res_c.echo_count = 2'd3;
               res_c.echo_a = CH_BS;
               res_c.echo_b = CH_SP;
               res_c.echo_c = CH_BS;
               res_c.line_length = count_ff - 1'b1;
               res_c.last = (count_ff == CNT_W'(1));
               out_valid_in = 1'b1;
               out_in = res_c;
               if (count_ff == CNT_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_RT_READ: begin
            // store read issued at idx_ff, data shows next cycle
            state_in = BK_RT_EMIT;
         end
         BK_RT_EMIT: begin
            if (slot_free) begin
               res_c.echo_count = 2'd1;
               res_c.echo_a = rd_data;
               res_c.line_length = count_ff;
               res_c.last = (idx_ff + 1'b1 == count_ff);
               out_valid_in = 1'b1;
               out_in = res_c;
               if (idx_ff + 1'b1 == count_ff) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = BK_RT_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         open_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         open_ff <= open_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.echo_count = out_ff.echo_count;
   assign rsp.echo_a = out_ff.echo_a;
   assign rsp.echo_b = out_ff.echo_b;
   assign rsp.echo_c = out_ff.echo_c;
   assign rsp.store_valid = out_ff.store_valid;
   assign rsp.store_index = out_ff.store_index;
   assign rsp.line_done = out_ff.line_done;
   assign rsp.line_length = out_ff.line_length;
   assign rsp.last = out_ff.last;
endmodule

// ===== rtl/console_line_editor.sv =====
// Top level of the console line editor: front end, command queue, back end.
// Depends on cle_pkg, cle_req_if, cle_rsp_if, cle_front, cle_queue, cle_back.
//
//   channel   dir  handshake         word
//   req_ch    in   valid/ready       opcode, char_in
//   rsp_ch    out  valid/ready       echo_count, echo_a..c, store_*, line_*, last
//   csr_*     in   write enable      max_chars (6 bits)
//
// Flow: the back end takes one command a cycle while idle and its result slot is
// free. Start, erase, newline and printable words give any result the cycle after
// leaving the queue. Kill gives one word a cycle while rsp_ch is ready. Retype
// gives the header, then each stored character through the registered store read.
// Reset is synchronous; the line store needs no clearing, so no sweep follows.
// A stalled result holds in the output register while the queue keeps filling.
`timescale 1ns / 1ps
module console_line_editor (
   input  logic                      clock,
   input  logic                      reset,
   cle_req_if.sink                   req_ch,
   cle_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [cle_pkg::CNT_W-1:0] csr_wdata
);
   import cle_pkg::*;

   logic [CNT_W-1:0] max_chars_ff;

   // front to queue
   logic    push_valid;
   cmd_type push_cmd;
   logic    push_ready;

   // queue to back
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop;

   // Line limit register; the back end clamps it to the line capacity.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_we) begin
         max_chars_ff <= csr_wdata;
      end
   end

   // Classifies words and drops codes that never produce output.
   cle_front u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Decouples input acceptance from multi-word commands (kill, retype).
   cle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   // Owns the line count, the open flag and the line store; drives the result word.
   cle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .max_chars (max_chars_ff),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp       (rsp_ch)
   );
endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checks on the console line editor result channel, bound to the top.
// Depends on console_line_editor_defines.svh and console_line_editor.
`timescale 1ns / 1ps
`include "console_line_editor_defines.svh"
module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] echo_count,
   input logic [7:0] echo_a,
   input logic [7:0] echo_b,
   input logic [7:0] echo_c,
   input logic       store_valid,
   input logic [5:0] store_index,
   input logic       line_done,
   input logic [5:0] line_length,
   input logic       last
);
   `CLE_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(echo_a) && $stable(line_length)
         && $stable(last),
      "stalled result word changed")
   `CLE_ASSERT(a_echo_zero,
      rsp_valid |-> (echo_count == 2'd3 || echo_c == 8'h00)
         && (echo_count == 2'd3 || echo_count == 2'd2 || echo_b == 8'h00),
      "echo beyond count not zero")
   `CLE_ASSERT(a_store_len,
      rsp_valid && store_valid |-> line_length == store_index + 6'd1
         && echo_count == 2'd1 && last && !line_done,
      "store word inconsistent")
   `CLE_ASSERT(a_done_last,
      rsp_valid && line_done |-> last && !store_valid,
      "line close not last word")
   `CLE_ASSERT_ALWAYS(a_reset_idle,
      $past(reset) |-> !rsp_valid,
      "result valid right after reset")
endmodule

bind console_line_editor cle_checker u_cle_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .echo_count  (rsp_ch.echo_count),
   .echo_a      (rsp_ch.echo_a),
   .echo_b      (rsp_ch.echo_b),
   .echo_c      (rsp_ch.echo_c),
   .store_valid (rsp_ch.store_valid),
   .store_index (rsp_ch.store_index),
   .line_done   (rsp_ch.line_done),
   .line_length (rsp_ch.line_length),
   .last        (rsp_ch.last)
);
